// File: src/mtts_pkg.sv
`timescale 1ns / 1ps

package mtts_pkg;

  localparam int MaxWidth      = 1024;
  localparam int MaxHeight     = 1024;
  localparam int TileSize      = 8;
  localparam int TexelsPerTile = TileSize * TileSize;

  localparam int CountW = 10;   // column and row counters
  localparam int SizeW  = 11;   // width and height registers
  localparam int TileW  = $clog2(TileSize);
  localparam int KW     = $clog2(TexelsPerTile);
  localparam int ColW   = $clog2(MaxWidth);
  localparam int AddrW  = TileW + ColW;
  localparam int PixW   = 32;
  localparam int IdxW   = 4;

  localparam logic [IdxW-1:0] REG_IMAGE_WIDTH  = IdxW'(0);
  localparam logic [IdxW-1:0] REG_IMAGE_HEIGHT = IdxW'(1);

  localparam logic [KW-1:0] K_LAST = KW'(TexelsPerTile - 1);

  typedef enum logic {
    ST_IDLE,
    ST_READOUT
  } state_t;

  typedef struct packed {
    logic          write_pix;
    logic          start_tile;
    logic          issue;
    logic [KW-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic tile_done;
    logic advance;
  } status_t;

  function automatic logic [PixW-1:0] swap_bytes(input logic [PixW-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Clear the low three bits, then clamp to 8..top.
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] r,
                                                  input logic [SizeW:0]   top);
    logic [SizeW-1:0] v;
    v = {r[SizeW-1:3], 3'b000};
    if (v < SizeW'(8)) v = SizeW'(8);
    if ({1'b0, v} > top) v = top[SizeW-1:0];
    return v;
  endfunction

endpackage

// File: src/mtts_ctrl.sv
`timescale 1ns / 1ps

module mtts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtts_pkg::status_t status,
  output mtts_pkg::cmd_t    cmd
);
  import mtts_pkg::*;

  state_t        state, state_next;
  logic [KW-1:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next     = state;
    k_next         = k;
    in_ready       = 1'b0;
    cmd.write_pix  = 1'b0;
    cmd.start_tile = 1'b0;
    cmd.issue      = 1'b0;
    cmd.k          = k;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.write_pix = in_valid;
        if (in_valid && status.tile_done) begin
          cmd.start_tile = 1'b1;
          k_next         = '0;
          state_next     = ST_READOUT;
        end
      end
      ST_READOUT: begin
        // issue one strip read per cycle the output pipe can move
        cmd.issue = status.advance;
        if (status.advance) begin
          k_next = k + KW'(1);
          if (k == K_LAST) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/mtts_datapath.sv
`timescale 1ns / 1ps

module mtts_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mtts_pkg::IdxW-1:0]    cfg_index,
  input  logic [mtts_pkg::SizeW-1:0]   cfg_data,
  input  logic [mtts_pkg::PixW-1:0]    pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mtts_pkg::PixW-1:0]    texel,
  output logic                         tile_last,
  output logic                         frame_last,
  input  mtts_pkg::cmd_t               cmd,
  output mtts_pkg::status_t            status
);
  import mtts_pkg::*;

  logic [SizeW-1:0]  width_reg, height_reg;
  logic [SizeW-1:0]  eff_w, eff_h;
  logic [CountW-1:0] col, row;
  logic              col_wrap, row_wrap;
  logic [ColW-TileW-1:0] tile_base;
  logic              frame_end;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [PixW-1:0]   strip_mem [2**AddrW];
  logic [PixW-1:0]   rd_q;
  logic              s1_valid, s1_tile_last, s1_frame_last;
  logic              advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= SizeW'(8);
      height_reg <= SizeW'(8);
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH)  width_reg  <= cfg_data;
      if (cfg_index == REG_IMAGE_HEIGHT) height_reg <= cfg_data;
    end
  end

  assign eff_w = clamp_size(width_reg,  (SizeW+1)'(MaxWidth));
  assign eff_h = clamp_size(height_reg, (SizeW+1)'(MaxHeight));

  assign col_wrap = ({1'b0, col} + SizeW'(1)) >= eff_w;
  assign row_wrap = ({1'b0, row} + SizeW'(1)) >= eff_h;

  assign status.tile_done = (col[TileW-1:0] == '1) && (row[TileW-1:0] == '1);
  assign status.advance   = advance;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.write_pix) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + CountW'(1);
      end else begin
        col <= col + CountW'(1);
      end
    end
  end

  // hold tile position and frame flag for the whole readout
  always_ff @(posedge clk) begin
    if (cmd.start_tile) begin
      tile_base <= col[ColW-1:TileW];
      frame_end <= col_wrap && row_wrap;
    end
  end

  assign wr_addr = {row[TileW-1:0], col[ColW-1:0]};
  // Z-order: column from even bits of k, row from odd bits
  assign rd_addr = {cmd.k[5], cmd.k[3], cmd.k[1], tile_base, cmd.k[4], cmd.k[2], cmd.k[0]};

  always_ff @(posedge clk) begin
    if (cmd.write_pix) strip_mem[wr_addr] <= pixel;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) rd_q <= strip_mem[rd_addr];
  end

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= cmd.issue;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tile_last  <= (cmd.k == K_LAST);
      s1_frame_last <= (cmd.k == K_LAST) && frame_end;
      texel         <= swap_bytes(rd_q);
      tile_last     <= s1_tile_last;
      frame_last    <= s1_frame_last;
    end
  end

endmodule

// File: src/morton_tile_texture_swizzle.sv
`timescale 1ns / 1ps
// Pixels enter one per cycle while in_ready is high. The pixel that completes
// an 8x8 tile starts a 64-texel readout. Texels leave one per cycle while
// out_ready is high, through the strip memory read register and the output
// register; in_ready stays low while the reads are issued.
// Reset clears counters and pipeline valids and sets both sizes to 8; the
// strip memory is not cleared.
module morton_tile_texture_swizzle (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mtts_pkg::IdxW-1:0]  cfg_index,
  input  logic [mtts_pkg::SizeW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mtts_pkg::PixW-1:0]  pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mtts_pkg::PixW-1:0]  texel,
  output logic                       tile_last,
  output logic                       frame_last
);
  import mtts_pkg::*;

  cmd_t    cmd;
  status_t status;

  mtts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mtts_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .texel      (texel),
    .tile_last  (tile_last),
    .frame_last (frame_last),
    .cmd        (cmd),
    .status     (status)
  );

`ifndef SYNTHESIS
  a_frame_on_tile: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last) |-> tile_last)
    else $error("frame_last without tile_last");

  a_tile_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && status.tile_done) |=> !in_ready)
    else $error("input accepted during tile readout");

  a_readout_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.k == K_LAST) |=> in_ready)
    else $error("readout did not return to idle");
`endif

endmodule
